/* design/matrix_flip_rotate_engine_macros.svh */
// assertion macros used by the checker file
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef MATRIX_FLIP_ROTATE_ENGINE_MACROS_SVH
`define MATRIX_FLIP_ROTATE_ENGINE_MACROS_SVH

// property checked on every clock edge outside reset
`define MFRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MFRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  `MFRE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* design/mfre_pkg.sv */
// shared constants, codes and types of the matrix flip / rotate engine
// no dependencies
`default_nettype none

package mfre_pkg;

  localparam int MAX_DIM = 128;
  localparam int ELEM_W  = 32;
  localparam int DIM_W   = 8;
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FUNC_W  = 2;
  localparam int OP_W    = 3;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START,
    FUNC_WRITE,
    FUNC_APPLY,
    FUNC_READ
  } func_e;

  localparam logic [OP_W-1:0] OP_VFLIP    = 3'd1;
  localparam logic [OP_W-1:0] OP_HFLIP    = 3'd2;
  localparam logic [OP_W-1:0] OP_ROT_CW   = 3'd3;
  localparam logic [OP_W-1:0] OP_ROT_CCW  = 3'd4;
  localparam logic [OP_W-1:0] OP_QUAD_CW  = 3'd5;
  localparam logic [OP_W-1:0] OP_QUAD_CCW = 3'd6;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_WDRAIN,
    ST_COPY,
    ST_CDRAIN,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic do_start;
    logic do_write;
    logic do_read;
    logic walk_begin;
    logic walk_step;
    logic copy_begin;
    logic copy_step;
    logic push_status;
    logic status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_valid;
    logic quad_refuse;
    logic walk_last;
    logic copy_last;
    logic pipe_busy;
    logic room;
  } dp_stat_t;

  typedef struct packed {
    logic [ELEM_W-1:0] data;
    logic              last;
    logic              status;
  } res_t;

endpackage

`default_nettype wire

/* design/mfre_stream_if.sv */
// valid/ready channel interfaces for the input and result words
// depends on mfre_pkg
`default_nettype none

interface mfre_in_if;
  logic                                valid;
  logic                                ready;
  logic        [mfre_pkg::FUNC_W-1:0]  func;
  logic signed [mfre_pkg::ELEM_W-1:0]  value;
  logic        [mfre_pkg::OP_W-1:0]    op;

  modport source (output valid, func, value, op, input ready);
  modport sink   (input valid, func, value, op, output ready);
endinterface

interface mfre_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mfre_pkg::ELEM_W-1:0]  data;
  logic                                last;
  logic                                status;

  modport source (output valid, data, last, status, input ready);
  modport sink   (input valid, data, last, status, output ready);
endinterface

`default_nettype wire

/* design/mfre_cfg.sv */
// apb register file holding the configured row and column counts
// depends on mfre_pkg
`default_nettype none

module mfre_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfre_pkg::APB_AW-1:0]   paddr,
  input  logic [mfre_pkg::APB_DW-1:0]   pwdata,
  output logic [mfre_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [mfre_pkg::DIM_W-1:0]    rows_o,
  output logic [mfre_pkg::DIM_W-1:0]    cols_o
);

  function automatic logic [mfre_pkg::DIM_W-1:0] clamp_dim(
    input logic [mfre_pkg::DIM_W-1:0] v
  );
    logic [mfre_pkg::DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = mfre_pkg::DIM_W'(1);
    end else if (int'(v) > mfre_pkg::MAX_DIM) begin
      r = mfre_pkg::DIM_W'(mfre_pkg::MAX_DIM);
    end
    return r;
  endfunction

  logic [mfre_pkg::DIM_W-1:0] rows_q, rows_d;
  logic [mfre_pkg::DIM_W-1:0] cols_q, cols_d;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[mfre_pkg::APB_AW-1];

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (wr_en) begin
      case (reg_sel)
        mfre_pkg::REG_ROWS: rows_d = clamp_dim(pwdata[mfre_pkg::DIM_W-1:0]);
        mfre_pkg::REG_COLS: cols_d = clamp_dim(pwdata[mfre_pkg::DIM_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= mfre_pkg::DIM_W'(mfre_pkg::MAX_DIM);
      cols_q <= mfre_pkg::DIM_W'(mfre_pkg::MAX_DIM);
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  always_comb begin
    case (reg_sel)
      mfre_pkg::REG_ROWS: prdata = mfre_pkg::APB_DW'(rows_q);
      mfre_pkg::REG_COLS: prdata = mfre_pkg::APB_DW'(cols_q);
      default:            prdata = '0;
    endcase
  end

  assign rows_o = rows_q;
  assign cols_o = cols_q;

endmodule

`default_nettype wire

/* design/mfre_ctrl.sv */
// controller state machine: accepts words, sequences transform walk and copy back
// depends on mfre_pkg
`default_nettype none

module mfre_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [mfre_pkg::FUNC_W-1:0]   in_func_i,
  output logic                          in_ready_o,
  input  mfre_pkg::dp_stat_t            stat_i,
  output mfre_pkg::ctrl_cmd_t           cmd_o
);

  mfre_pkg::state_e state_q, state_d;
  logic             status_q, status_d;
  logic             accept;

  assign accept = in_valid_i && stat_i.room && (state_q == mfre_pkg::ST_IDLE);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    case (state_q)
      mfre_pkg::ST_IDLE: begin
        if (in_valid_i && stat_i.room && in_func_i == mfre_pkg::FUNC_APPLY) begin
          if (stat_i.op_valid && !stat_i.quad_refuse) begin
            state_d = mfre_pkg::ST_WALK;
          end else begin
            state_d  = mfre_pkg::ST_REPORT;
            status_d = stat_i.quad_refuse;
          end
        end
      end
      mfre_pkg::ST_WALK: begin
        if (stat_i.walk_last) state_d = mfre_pkg::ST_WDRAIN;
      end
      mfre_pkg::ST_WDRAIN: begin
        if (!stat_i.pipe_busy) state_d = mfre_pkg::ST_COPY;
      end
      mfre_pkg::ST_COPY: begin
        if (stat_i.copy_last) state_d = mfre_pkg::ST_CDRAIN;
      end
      mfre_pkg::ST_CDRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d  = mfre_pkg::ST_REPORT;
          status_d = 1'b0;
        end
      end
      mfre_pkg::ST_REPORT: begin
        if (stat_i.room) state_d = mfre_pkg::ST_IDLE;
      end
      default: state_d = mfre_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.status = status_q;
    case (state_q)
      mfre_pkg::ST_IDLE: begin
        in_ready_o = stat_i.room;
        if (accept) begin
          case (in_func_i)
            mfre_pkg::FUNC_START: cmd_o.do_start = 1'b1;
            mfre_pkg::FUNC_WRITE: cmd_o.do_write = 1'b1;
            mfre_pkg::FUNC_READ:  cmd_o.do_read  = 1'b1;
            mfre_pkg::FUNC_APPLY: cmd_o.walk_begin = stat_i.op_valid && !stat_i.quad_refuse;
            default: ;
          endcase
        end
      end
      mfre_pkg::ST_WALK:   cmd_o.walk_step = 1'b1;
      mfre_pkg::ST_WDRAIN: cmd_o.copy_begin = !stat_i.pipe_busy;
      mfre_pkg::ST_COPY:   cmd_o.copy_step = 1'b1;
      mfre_pkg::ST_CDRAIN: ;
      mfre_pkg::ST_REPORT: cmd_o.push_status = stat_i.room;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mfre_pkg::ST_IDLE;
      status_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

/* design/mfre_datapath.sv */
// datapath: picture and scratch memories, pointers, address pipeline, result queue
// depends on mfre_pkg
`default_nettype none

module mfre_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mfre_pkg::ctrl_cmd_t                 cmd_i,
  output mfre_pkg::dp_stat_t                  stat_o,
  input  logic        [mfre_pkg::DIM_W-1:0]   cfg_rows_i,
  input  logic        [mfre_pkg::DIM_W-1:0]   cfg_cols_i,
  input  logic signed [mfre_pkg::ELEM_W-1:0]  in_value_i,
  input  logic        [mfre_pkg::OP_W-1:0]    in_op_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mfre_pkg::ELEM_W-1:0]  out_data_o,
  output logic                                out_last_o,
  output logic                                out_status_o
);

  localparam int DIM_W = mfre_pkg::DIM_W;
  localparam int POS_W = mfre_pkg::POS_W;
  localparam int IDX_W = mfre_pkg::IDX_W;
  localparam int CNT_W = mfre_pkg::CNT_W;
  localparam int EW    = mfre_pkg::ELEM_W;

  // size and pointers
  logic [DIM_W-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic [IDX_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;

  // transform walk
  logic [mfre_pkg::OP_W-1:0] op_q, op_d;
  logic [POS_W-1:0] row_q, row_d, col_q, col_d;
  logic [IDX_W-1:0] dst_q, dst_d;
  logic             s1_v_q, s2_v_q, s3_v_q;
  logic [POS_W-1:0] s1_sr_q, s1_sc_q;
  logic [IDX_W-1:0] s1_dst_q, s2_dst_q, s3_dst_q, s2_addr_q;
  logic [POS_W-1:0] src_r, src_c;
  logic [CNT_W-1:0] addr_full;

  // copy back
  logic [IDX_W-1:0] cp_q, cp_d, c1_idx_q;
  logic             c1_v_q;

  // read return
  logic             rd_pend_q, rd_last_q;

  // memories
  logic [EW-1:0]    pic_mem [mfre_pkg::DEPTH];
  logic [EW-1:0]    scr_mem [mfre_pkg::DEPTH];
  logic [EW-1:0]    pic_rd_q, scr_rd_q, pic_wdata;
  logic [IDX_W-1:0] pic_raddr, pic_waddr;
  logic             pic_we;

  // result queue
  mfre_pkg::res_t   fifo_q [2];
  mfre_pkg::res_t   push_word;
  logic             fifo_wp_q, fifo_rp_q;
  logic [1:0]       fifo_cnt_q;
  logic             push, pop;
  logic [2:0]       fill_next;

  logic             rot;
  logic [DIM_W-1:0] nr, nc, nr_m1, nc_m1;
  logic             col_end;
  logic [DIM_W-1:0] r_ext, c_ext, hr, hc;
  logic             top, left;
  logic [DIM_W-1:0] sr, sc;
  logic [CNT_W-1:0] wr_next, rd_next;

  assign rot     = (op_q == mfre_pkg::OP_ROT_CW) || (op_q == mfre_pkg::OP_ROT_CCW);
  assign nr      = rot ? cols_q : rows_q;
  assign nc      = rot ? rows_q : cols_q;
  assign nr_m1   = nr - DIM_W'(1);
  assign nc_m1   = nc - DIM_W'(1);
  assign col_end = DIM_W'(col_q) == nc_m1;

  // source coordinates of the element landing at (row_q, col_q)
  always_comb begin
    r_ext = DIM_W'(row_q);
    c_ext = DIM_W'(col_q);
    hr    = rows_q >> 1;
    hc    = cols_q >> 1;
    top   = r_ext < hr;
    left  = c_ext < hc;
    sr    = r_ext;
    sc    = c_ext;
    case (op_q)
      mfre_pkg::OP_VFLIP:   sr = rows_q - DIM_W'(1) - r_ext;
      mfre_pkg::OP_HFLIP:   sc = cols_q - DIM_W'(1) - c_ext;
      mfre_pkg::OP_ROT_CW: begin
        sr = rows_q - DIM_W'(1) - c_ext;
        sc = r_ext;
      end
      mfre_pkg::OP_ROT_CCW: begin
        sr = c_ext;
        sc = cols_q - DIM_W'(1) - r_ext;
      end
      mfre_pkg::OP_QUAD_CW: begin
        if (top && left)  sr = r_ext + hr;
        else if (top)     sc = c_ext - hc;
        else if (!left)   sr = r_ext - hr;
        else              sc = c_ext + hc;
      end
      mfre_pkg::OP_QUAD_CCW: begin
        if (top && left)  sc = c_ext + hc;
        else if (top)     sr = r_ext + hr;
        else if (!left)   sc = c_ext - hc;
        else              sr = r_ext - hr;
      end
      default: ;
    endcase
    src_r = sr[POS_W-1:0];
    src_c = sc[POS_W-1:0];
  end

  assign addr_full = CNT_W'(s1_sr_q) * CNT_W'(cols_q) + CNT_W'(s1_sc_q);

  assign wr_next = CNT_W'(wr_ptr_q) + CNT_W'(1);
  assign rd_next = CNT_W'(rd_ptr_q) + CNT_W'(1);

  always_comb begin
    rows_d   = rows_q;
    cols_d   = cols_q;
    total_d  = total_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    op_d     = op_q;
    row_d    = row_q;
    col_d    = col_q;
    dst_d    = dst_q;
    cp_d     = cp_q;
    if (cmd_i.do_start) begin
      rows_d   = cfg_rows_i;
      cols_d   = cfg_cols_i;
      total_d  = CNT_W'(cfg_rows_i) * CNT_W'(cfg_cols_i);
      wr_ptr_d = '0;
      rd_ptr_d = '0;
    end
    if (cmd_i.do_write) begin
      wr_ptr_d = (wr_next >= total_q) ? '0 : wr_next[IDX_W-1:0];
    end
    if (cmd_i.do_read) begin
      rd_ptr_d = (rd_next >= total_q) ? '0 : rd_next[IDX_W-1:0];
    end
    if (cmd_i.walk_begin) begin
      op_d  = in_op_i;
      row_d = '0;
      col_d = '0;
      dst_d = '0;
    end
    if (cmd_i.walk_step) begin
      dst_d = dst_q + IDX_W'(1);
      if (col_end) begin
        col_d = '0;
        row_d = row_q + POS_W'(1);
      end else begin
        col_d = col_q + POS_W'(1);
      end
    end
    if (cmd_i.copy_begin) begin
      cp_d = '0;
      if (rot) begin
        rows_d = cols_q;
        cols_d = rows_q;
      end
    end
    if (cmd_i.copy_step) begin
      cp_d = cp_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= DIM_W'(mfre_pkg::MAX_DIM);
      cols_q     <= DIM_W'(mfre_pkg::MAX_DIM);
      total_q    <= CNT_W'(mfre_pkg::DEPTH);
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      c1_v_q     <= 1'b0;
      rd_pend_q  <= 1'b0;
      fifo_wp_q  <= 1'b0;
      fifo_rp_q  <= 1'b0;
      fifo_cnt_q <= '0;
    end else begin
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      total_q    <= total_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      s1_v_q     <= cmd_i.walk_step;
      s2_v_q     <= s1_v_q;
      s3_v_q     <= s2_v_q;
      c1_v_q     <= cmd_i.copy_step;
      rd_pend_q  <= cmd_i.do_read;
      if (push) fifo_wp_q <= ~fifo_wp_q;
      if (pop)  fifo_rp_q <= ~fifo_rp_q;
      fifo_cnt_q <= fill_next[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    row_q     <= row_d;
    col_q     <= col_d;
    dst_q     <= dst_d;
    cp_q      <= cp_d;
    s1_sr_q   <= src_r;
    s1_sc_q   <= src_c;
    s1_dst_q  <= dst_q;
    s2_addr_q <= addr_full[IDX_W-1:0];
    s2_dst_q  <= s1_dst_q;
    s3_dst_q  <= s2_dst_q;
    c1_idx_q  <= cp_q;
    rd_last_q <= rd_next >= total_q;
    if (push) fifo_q[fifo_wp_q] <= push_word;
  end

  // picture memory: one write port, one registered read port
  assign pic_raddr = s2_v_q ? s2_addr_q : rd_ptr_q;
  assign pic_we    = cmd_i.do_write || c1_v_q;
  assign pic_waddr = c1_v_q ? c1_idx_q : wr_ptr_q;
  assign pic_wdata = c1_v_q ? scr_rd_q : EW'(in_value_i);

  always_ff @(posedge clk_i) begin
    if (pic_we) pic_mem[pic_waddr] <= pic_wdata;
    pic_rd_q <= pic_mem[pic_raddr];
  end

  // scratch memory
  always_ff @(posedge clk_i) begin
    if (s3_v_q) scr_mem[s3_dst_q] <= pic_rd_q;
    scr_rd_q <= scr_mem[cp_q];
  end

  // result queue, two words deep
  always_comb begin
    push_word = '0;
    if (rd_pend_q) begin
      push_word.data = pic_rd_q;
      push_word.last = rd_last_q;
    end else begin
      push_word.status = cmd_i.status;
    end
  end

  assign push      = rd_pend_q || cmd_i.push_status;
  assign pop       = out_valid_o && out_ready_i;
  assign fill_next = 3'(fifo_cnt_q) + 3'(push) - 3'(pop);

  assign out_valid_o  = fifo_cnt_q != '0;
  assign out_data_o   = fifo_q[fifo_rp_q].data;
  assign out_last_o   = fifo_q[fifo_rp_q].last;
  assign out_status_o = fifo_q[fifo_rp_q].status;

  always_comb begin
    stat_o             = '0;
    stat_o.op_valid    = (in_op_i >= mfre_pkg::OP_VFLIP) && (in_op_i <= mfre_pkg::OP_QUAD_CCW);
    stat_o.quad_refuse = ((in_op_i == mfre_pkg::OP_QUAD_CW) ||
                          (in_op_i == mfre_pkg::OP_QUAD_CCW)) && (rows_q[0] || cols_q[0]);
    stat_o.walk_last   = col_end && (DIM_W'(row_q) == nr_m1);
    stat_o.copy_last   = (CNT_W'(cp_q) + CNT_W'(1)) == total_q;
    stat_o.pipe_busy   = s1_v_q || s2_v_q || s3_v_q || c1_v_q;
    stat_o.room        = (3'(fifo_cnt_q) + 3'(rd_pend_q) - 3'(pop)) < 3'd2;
  end

endmodule

`default_nettype wire

/* design/matrix_flip_rotate_engine.sv */
// write and start words: one per cycle while the input is ready, no result
// read words: one per cycle while the input is ready, result through a two-word queue
// apply word: status word after walk, walk drain, copy back, copy drain and report, input
// held meanwhile; refused or unknown op: status word straight from report
// reset: asynchronous active low; size registers and current size go to 128, pointers
// to zero, memories are not cleared
`default_nettype none

module matrix_flip_rotate_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mfre_in_if.sink                       in_i,
  mfre_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfre_pkg::APB_AW-1:0]   paddr,
  input  logic [mfre_pkg::APB_DW-1:0]   pwdata,
  output logic [mfre_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [mfre_pkg::DIM_W-1:0] cfg_rows, cfg_cols;
  mfre_pkg::ctrl_cmd_t        cmd;
  mfre_pkg::dp_stat_t         stat;

  mfre_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows_o  (cfg_rows),
    .cols_o  (cfg_cols)
  );

  mfre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mfre_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_rows_i   (cfg_rows),
    .cfg_cols_i   (cfg_cols),
    .in_value_i   (in_i.value),
    .in_op_i      (in_i.op),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_data_o   (out_o.data),
    .out_last_o   (out_o.last),
    .out_status_o (out_o.status)
  );

endmodule

`default_nettype wire

/* design/mfre_checker.sv */
// port-level checks of the engine, attached to the top level by bind
// depends on mfre_pkg and matrix_flip_rotate_engine_macros.svh
`default_nettype none
`include "matrix_flip_rotate_engine_macros.svh"

module mfre_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [mfre_pkg::FUNC_W-1:0]   in_func,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mfre_pkg::ELEM_W-1:0]   out_data,
  input logic                          out_last,
  input logic                          out_status
);

  logic acc;
  logic acc_read;
  logic acc_quiet;

  assign acc       = in_valid && in_ready;
  assign acc_read  = acc && (in_func == mfre_pkg::FUNC_READ);
  assign acc_quiet = acc && ((in_func == mfre_pkg::FUNC_START) ||
                             (in_func == mfre_pkg::FUNC_WRITE));

  // stalled word holds
  `MFRE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_data) && $stable(out_last) && $stable(out_status),
    "result word changed while stalled")

  // apply blocks the input on the next cycle
  `MFRE_ASSERT_NEXT(a_apply_busy, acc && (in_func == mfre_pkg::FUNC_APPLY), !in_ready,
    "input still open after apply")

  // read word and status word never mix
  `MFRE_ASSERT(a_last_status, out_valid |-> !(out_last && out_status),
    "result word has both last and status")

  // start and write words produce no result
  `MFRE_ASSERT_NEXT(a_quiet, acc_quiet && !out_valid && !$past(acc_read), !out_valid,
    "result appeared after start or write")

endmodule

bind matrix_flip_rotate_engine mfre_checker u_mfre_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .in_func    (in_i.func),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_data   (out_o.data),
  .out_last   (out_o.last),
  .out_status (out_o.status)
);

`default_nettype wire
